// File: sv/mmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared types and constants for the int8 systolic matmul tile.
// ----------------------------------------------------------------------------
package mmt_pkg;

	localparam int ACC_W  = 48;
	localparam int NARROW = 24;
	localparam int KLEN_W = 16;
	localparam int IDX_W  = 3;
	localparam int OUT_W  = 56;
	localparam int IN_W   = 128;
	localparam int VEC_W  = 64;

	localparam logic [KLEN_W-1:0] KLEN_RESET = 16'd768;

	typedef logic [ACC_W-1:0] acc_t;

	typedef enum logic {
		CFG_K_LENGTH    = 1'b0,
		CFG_PACKED_MODE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic step;
		logic packed_mode;
		logic clear;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/mmt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_cell
// One output-stationary accumulator cell: plain 8x8 MAC or packed 8x4 dual MAC.
// ----------------------------------------------------------------------------
module mmt_cell
	import mmt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic [7:0] a_byte,
	input  wire logic [7:0] b_byte,
	output acc_t            acc
);

	acc_t               acc_q;
	logic signed [7:0]  a_s;
	logic signed [7:0]  b_s;
	logic signed [17:0] pb_s;
	logic signed [24:0] pk;
	logic signed [15:0] pl;
	logic [NARROW-1:0]  plain_sum;
	acc_t               packed_sum;

	always_comb begin
		a_s        = $signed(a_byte);
		b_s        = $signed(b_byte);
		pb_s       = $signed({b_byte[7], b_byte[7:4], 9'd0, b_byte[3:0]});
		pk         = a_s * pb_s;
		pl         = a_s * b_s;
		plain_sum  = acc_q[NARROW-1:0] + {{(NARROW-16){pl[15]}}, pl};
		packed_sum = acc_q + {12'd0, pk[24:13], 12'd0, pk[11:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.step) begin
			if (ctrl.packed_mode) begin
				acc_q <= packed_sum;
			end else begin
				acc_q <= {{(ACC_W-NARROW){1'b0}}, plain_sum};
			end
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// File: sv/mmt_drain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_drain
// Merges the cell array into one result stream, column-major, one beat a cycle while the sink is ready.
// ----------------------------------------------------------------------------
module mmt_drain
	import mmt_pkg::*;
#(
	parameter int TILE = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             start_packed,
	input  wire acc_t             acc [TILE][TILE],
	output logic                  busy,
	output logic                  clear,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,   // row_index, col_index, sum_value, pad
	output logic                  m_axis_tlast
);

	localparam int RC_W = $clog2(TILE);

	logic            busy_q;
	logic            packed_q;
	logic [RC_W-1:0] row_q;
	logic [RC_W-1:0] col_q;
	logic            out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic            out_last_q;
	logic            load;
	logic            row_end;
	logic            col_end;
	acc_t            sel;
	acc_t            sum;

	always_comb begin
		load    = busy_q && (!out_valid_q || m_axis_tready);
		row_end = row_q == RC_W'(TILE - 1);
		col_end = col_q == RC_W'(TILE - 1);
		sel     = acc[row_q][col_q];
		sum     = packed_q ? sel : {{(ACC_W-NARROW){sel[NARROW-1]}}, sel[NARROW-1:0]};
		clear   = load && row_end && col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			packed_q    <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (start) begin
				busy_q   <= 1'b1;
				packed_q <= start_packed;
				row_q    <= '0;
				col_q    <= '0;
			end else if (load) begin
				if (row_end) begin
					row_q <= '0;
					col_q <= col_q + RC_W'(1);
					if (col_end) begin
						busy_q <= 1'b0;
					end
				end else begin
					row_q <= row_q + RC_W'(1);
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
				out_last_q  <= row_end && col_end;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {2'b00, sum, IDX_W'(col_q), IDX_W'(row_q)};
		end
	end

	assign busy          = busy_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: sv/int8_systolic_matmul_tile_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int8_systolic_matmul_tile_top
// Output-stationary TILE x TILE int8 matmul tile with plain and packed MAC.
// ----------------------------------------------------------------------------
// Each input beat is one k-step, absorbed by a single update of the cells: all
// TILE*TILE cells multiply-accumulate in parallel, so steps stream at one
// beat per cycle while the tile is not draining. After k_length steps (zero
// counts as one) the tile drains through a single output register, one
// accumulator per cycle in column-major order while the sink is ready;
// the input is held off for the drain and the cells clear on its last beat.
// Input tdata: a_vector in [63:0], b_vector in [127:64]. Output tdata:
// row_index [2:0], col_index [5:3], sum_value [53:6]; tlast marks tile_last.
// ----------------------------------------------------------------------------
module int8_systolic_matmul_tile_top
	import mmt_pkg::*;
#(
	parameter int TILE = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [IN_W-1:0]   s_axis_tdata,   // a_vector, b_vector
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata,   // row_index, col_index, sum_value
	output logic                   m_axis_tlast,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [KLEN_W-1:0] cfg_data
);

	logic [KLEN_W-1:0] k_length_q;
	logic              packed_q;
	logic [KLEN_W-1:0] step_q;
	logic [KLEN_W-1:0] step_next;
	logic [KLEN_W-1:0] limit;
	logic              accept;
	logic              emit;
	logic              busy;
	logic              clear;
	cell_ctrl_t        ctrl;
	acc_t              acc [TILE][TILE];

	always_comb begin
		accept    = s_axis_tvalid && s_axis_tready;
		step_next = step_q + KLEN_W'(1);
		limit     = (k_length_q == '0) ? KLEN_W'(1) : k_length_q;
		emit      = accept && (step_next >= limit);
		ctrl      = '{step: accept, packed_mode: packed_q, clear: clear};
	end

	assign s_axis_tready = !busy;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_length_q <= KLEN_RESET;
			packed_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_K_LENGTH:    k_length_q <= cfg_data;
				CFG_PACKED_MODE: packed_q   <= cfg_data[0];
				default:         k_length_q <= k_length_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (emit) begin
			step_q <= '0;
		end else if (accept) begin
			step_q <= step_next;
		end
	end

	for (genvar m = 0; m < TILE; m++) begin : g_row
		for (genvar n = 0; n < TILE; n++) begin : g_col
			mmt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.a_byte (s_axis_tdata[8*m +: 8]),
				.b_byte (s_axis_tdata[VEC_W + 8*n +: 8]),
				.acc    (acc[m][n])
			);
		end
	end

	mmt_drain #(
		.TILE (TILE)
	) u_drain (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (emit),
		.start_packed  (packed_q),
		.acc           (acc),
		.busy          (busy),
		.clear         (clear),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the int8 systolic matmul tile.
// ----------------------------------------------------------------------------
// Streams k-step beats of A and B bytes into the tile. A predictor keeps its
// own accumulators, step count, tile length and mode, and queues the 64
// column-major sums of each completed tile. Every output beat is checked
// against the oldest queued sum. The directed tests cover the reset
// configuration, byte extremes in both modes, zero and maximum tile length,
// lowering the length mid-tile and mode changes mid-tile. A long random run
// follows. Both sides stall in random bursts, except near the end.
// ----------------------------------------------------------------------------
module tb;
	import mmt_pkg::*;

	localparam int TILE = 8;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [ACC_W-1:0] sum;
		logic             last;
	} tile_sum_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;   // a_vector, b_vector
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;        // row_index, col_index, sum_value
	logic              m_axis_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = CFG_K_LENGTH;
	logic [KLEN_W-1:0] cfg_data = '0;

	logic [ACC_W-1:0]  cell_sum [TILE][TILE];
	logic [KLEN_W-1:0] steps_done;
	logic [KLEN_W-1:0] tile_len;
	logic              packed_on;
	tile_sum_t         pending_sums [$];

	int errors = 0;
	int sink_hold = 0;
	bit quiet = 1'b0;

	int8_systolic_matmul_tile_top #(
		.TILE(TILE)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#17_000_000;
		$display("tb failed");
		$finish;
	end

	// Update all cells for one k-step and queue the tile when it completes.
	task automatic mac_step(input logic [VEC_W-1:0] a_vec, input logic [VEC_W-1:0] b_vec);
		logic signed [7:0] a8;
		logic signed [7:0] b8;
		logic signed [3:0] h4;
		logic [24:0]       p;
		int                a;
		int                prod;
		int                limit;
		tile_sum_t         s;
		for (int m = 0; m < TILE; m++) begin
			a8 = a_vec[8*m +: 8];
			a = a8;
			for (int n = 0; n < TILE; n++) begin
				b8 = b_vec[8*n +: 8];
				h4 = b_vec[8*n+4 +: 4];
				if (packed_on) begin
					prod = a * (int'(h4) * 8192 + int'(b_vec[8*n +: 4]));
					p = prod[24:0];
					cell_sum[m][n] = cell_sum[m][n] + {12'd0, p[24:13], 12'd0, p[11:0]};
				end else begin
					prod = a * int'(b8);
					cell_sum[m][n] = {24'd0, cell_sum[m][n][NARROW-1:0] + prod[NARROW-1:0]};
				end
			end
		end
		steps_done = steps_done + KLEN_W'(1);
		limit = (tile_len == 0) ? 1 : int'(tile_len);
		if (int'(steps_done) >= limit) begin
			for (int n = 0; n < TILE; n++) begin
				for (int m = 0; m < TILE; m++) begin
					s.row = 3'(m);
					s.col = 3'(n);
					s.sum = packed_on ? cell_sum[m][n]
						: {{(ACC_W-NARROW){cell_sum[m][n][NARROW-1]}},
							cell_sum[m][n][NARROW-1:0]};
					s.last = (m == TILE-1) && (n == TILE-1);
					pending_sums.push_back(s);
					cell_sum[m][n] = '0;
				end
			end
			steps_done = '0;
		end
	endtask

	task automatic send_step(input logic [VEC_W-1:0] a_vec, input logic [VEC_W-1:0] b_vec);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b_vec, a_vec};
		do @(posedge clk); while (!s_axis_tready);
		mac_step(a_vec, b_vec);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [KLEN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_K_LENGTH:    tile_len = val;
			CFG_PACKED_MODE: packed_on = val[0];
		endcase
		@(posedge clk);
	endtask

	// Drop valid, wait for every queued sum, then let the pipeline go quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [VEC_W-1:0] rand_lanes();
		logic [VEC_W-1:0] v;
		for (int i = 0; i < TILE; i++) begin
			case ($urandom_range(0, 7))
				0: v[8*i +: 8] = 8'h80;
				1: v[8*i +: 8] = 8'h7F;
				2: v[8*i +: 8] = 8'h00;
				3: v[8*i +: 8] = 8'hFF;
				default: v[8*i +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return v;
	endfunction

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			sink_hold <= $urandom_range(0, 12);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		tile_sum_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected result beat, tdata %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_sums.pop_front();
				if (m_axis_tdata[2:0] !== want.row) begin
					$error("row_index: expected %0d, actual %0d", want.row, m_axis_tdata[2:0]);
					errors++;
				end
				if (m_axis_tdata[5:3] !== want.col) begin
					$error("col_index: expected %0d, actual %0d", want.col, m_axis_tdata[5:3]);
					errors++;
				end
				if (m_axis_tdata[53:6] !== want.sum) begin
					$error("sum_value: expected %h, actual %h", want.sum, m_axis_tdata[53:6]);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("tile_last: expected %0b, actual %0b", want.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	task automatic test_reset_state();
		send_step(64'h8080808080808080, 64'h8080808080808080);
		send_step(64'h7F7F7F7F7F7F7F7F, 64'h7F807F807F807F80);
		send_step(64'h00FF7F80017E81FE, 64'h8F7F0FF0FF00807F);
		settle();
		write_reg(CFG_K_LENGTH, 16'd2);
		send_step(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
		settle();
	endtask

	task automatic test_plain_extremes();
		write_reg(CFG_PACKED_MODE, 16'd0);
		write_reg(CFG_K_LENGTH, 16'd1);
		send_step(64'h8080808080808080, 64'h8080808080808080);
		send_step(64'h7F7F7F7F7F7F7F7F, 64'h8080808080808080);
		send_step(64'hFFFFFFFFFFFFFFFF, 64'h01FF7F80017F80FF);
		settle();
		write_reg(CFG_K_LENGTH, 16'd0);
		send_step(64'h807F00FF01FE7F80, 64'h7F7F7F7F7F7F7F7F);
		send_step(64'h1122334455667788, 64'h99AABBCCDDEEFF00);
		settle();
	endtask

	task automatic test_mode_switch();
		write_reg(CFG_K_LENGTH, 16'd4);
		write_reg(CFG_PACKED_MODE, 16'd1);
		send_step(64'h8080808080808080, 64'h8F8F8F8F8F8F8F8F);
		send_step(64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F);
		settle();
		write_reg(CFG_PACKED_MODE, 16'd0);
		send_step(64'h80FF7F0180FF7F01, 64'h7F80017F80FF0180);
		settle();
		write_reg(CFG_PACKED_MODE, 16'd1);
		send_step(64'hC3A5965A3C0FF0E1, 64'h0F1E2D3C4B5A6978);
		settle();
	endtask

	task automatic test_max_length();
		write_reg(CFG_K_LENGTH, 16'hFFFF);
		send_step(64'h8080808080808080, 64'h8080808080808080);
		send_step(64'h7F7F7F7F7F7F7F7F, 64'hF0F0F0F0F0F0F0F0);
		send_step(64'hFF01FF01FF01FF01, 64'h0F0F0F0F0F0F0F0F);
		settle();
		write_reg(CFG_K_LENGTH, 16'd1);
		send_step(64'h807F807F807F807F, 64'h8F7F8F7F8F7F8F7F);
		settle();
	endtask

	task automatic test_packed_nibbles();
		write_reg(CFG_PACKED_MODE, 16'd1);
		send_step(64'h8080808080808080, 64'h8F8F8F8F8F8F8F8F);
		send_step(64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F);
		send_step(64'h0101010101010101, 64'hF0F0F0F0F0F0F0F0);
		send_step(64'h80FF017F80FF017F, 64'h08F880700FFF0180);
		settle();
	endtask

	task automatic test_random_tiles();
		int sent;
		int len;
		int j;
		sent = 0;
		while (sent < 440) begin
			quiet = (sent >= 380);
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
			write_reg(CFG_K_LENGTH, 16'(len));
			write_reg(CFG_PACKED_MODE, 16'($urandom_range(0, 1)));
			j = 0;
			while (j < len) begin
				if (j > 0 && $urandom_range(0, 15) == 0) begin
					settle();
					write_reg(CFG_PACKED_MODE, 16'($urandom_range(0, 1)));
				end else if (j > 0 && $urandom_range(0, 15) == 0) begin
					settle();
					write_reg(CFG_K_LENGTH, 16'($urandom_range(1, j)));
					len = j + 1;
				end
				send_step(rand_lanes(), rand_lanes());
				sent++;
				j++;
			end
			settle();
		end
	endtask

	initial begin
		for (int m = 0; m < TILE; m++)
			for (int n = 0; n < TILE; n++)
				cell_sum[m][n] = '0;
		steps_done = '0;
		tile_len = KLEN_RESET;
		packed_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_plain_extremes();
		test_mode_switch();
		test_max_length();
		test_packed_nibbles();
		test_random_tiles();
		settle();
		repeat (80) @(posedge clk);
		if (errors == 0 && pending_sums.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
